// File: rtl/rdu_pkg.sv
// Shared types, constants, rounding and saturation helpers for the refraction direction unit.
package rdu_pkg;

    localparam int FRAC_BITS_DEF = 12;
    localparam int LANES         = 3;
    localparam int CALC_W        = 96;
    localparam int LEN_RAD_W     = 48;
    localparam int LEN_W         = 24;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic        [15:0] index_ratio;
    } t_rdu_in;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic               ok;
    } t_rdu_out;

    // divide by 2^sh, round to nearest, ties away from zero
    function automatic logic signed [CALC_W-1:0] rnd_sh(input logic signed [CALC_W-1:0] v,
                                                        input int unsigned sh);
        logic [CALC_W-1:0] m;
        m = v[CALC_W-1] ? CALC_W'(-v) : CALC_W'(v);
        m = (m + (CALC_W'(1) << (sh - 1))) >> sh;
        return v[CALC_W-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [CALC_W-1:0] v);
        logic signed [15:0] res;
        if (v > CALC_W'(32767)) begin
            res = 16'sh7fff;
        end else if (v < -CALC_W'(32768)) begin
            res = 16'sh8000;
        end else begin
            res = 16'(v);
        end
        return res;
    endfunction

endpackage

// File: rtl/rdu_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband tag.
module rdu_isqrt #(
    parameter int W  = 48,
    parameter int TW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [W-1:0]     i_rad,
    input  logic [TW-1:0]    i_tag,
    output logic             o_valid,
    output logic [W/2-1:0]   o_root,
    output logic [TW-1:0]    o_tag
);

    localparam int N  = W / 2;
    localparam int RW = N + 2;

    logic          r_vld  [N];
    logic [W-1:0]  r_rad  [N];
    logic [RW-1:0] r_rem  [N];
    logic [N-1:0]  r_root [N];
    logic [TW-1:0] r_tag  [N];

    logic          w_src_vld  [N];
    logic [W-1:0]  w_src_rad  [N];
    logic [RW-1:0] w_src_rem  [N];
    logic [N-1:0]  w_src_root [N];
    logic [TW-1:0] w_src_tag  [N];
    logic [RW-1:0] w_rem2     [N];
    logic [RW-1:0] w_trial    [N];
    logic [RW-1:0] n_rem      [N];
    logic [N-1:0]  n_root     [N];

    always_comb begin
        w_src_vld[0]  = i_valid;
        w_src_rad[0]  = i_rad;
        w_src_rem[0]  = '0;
        w_src_root[0] = '0;
        w_src_tag[0]  = i_tag;
        for (int k = 1; k < N; k++) begin
            w_src_vld[k]  = r_vld[k-1];
            w_src_rad[k]  = r_rad[k-1];
            w_src_rem[k]  = r_rem[k-1];
            w_src_root[k] = r_root[k-1];
            w_src_tag[k]  = r_tag[k-1];
        end
        for (int k = 0; k < N; k++) begin
            w_rem2[k]  = {w_src_rem[k][RW-3:0], w_src_rad[k][W-1:W-2]};
            w_trial[k] = {w_src_root[k], 2'b01};
            if (w_rem2[k] >= w_trial[k]) begin
                n_rem[k]  = w_rem2[k] - w_trial[k];
                n_root[k] = {w_src_root[k][N-2:0], 1'b1};
            end else begin
                n_rem[k]  = w_rem2[k];
                n_root[k] = {w_src_root[k][N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < N; k++) r_vld[k] <= w_src_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_rad[k]  <= w_src_rad[k] << 2;
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_tag[k]  <= w_src_tag[k];
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_root[N-1];
    assign o_tag   = r_tag[N-1];

endmodule

// File: rtl/rdu_div.sv
// Pipelined restoring divider, three lanes over one shared divisor, one quotient bit per stage.
module rdu_div #(
    parameter int NW = 37,
    parameter int DW = 24,
    parameter int QW = 14,
    parameter int TW = 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [rdu_pkg::LANES-1:0][NW-1:0]     i_num,
    input  logic [DW-1:0]                         i_den,
    input  logic [TW-1:0]                         i_tag,
    output logic                                  o_valid,
    output logic [rdu_pkg::LANES-1:0][QW-1:0]     o_quo,
    output logic [TW-1:0]                         o_tag
);

    localparam int NL = rdu_pkg::LANES;
    localparam int CW = NW + QW;

    logic                   r_vld [QW];
    logic [NL-1:0][NW-1:0]  r_rem [QW];
    logic [NL-1:0][QW-1:0]  r_quo [QW];
    logic [DW-1:0]          r_den [QW];
    logic [TW-1:0]          r_tag [QW];

    logic                   w_src_vld [QW];
    logic [NL-1:0][NW-1:0]  w_src_rem [QW];
    logic [NL-1:0][QW-1:0]  w_src_quo [QW];
    logic [DW-1:0]          w_src_den [QW];
    logic [TW-1:0]          w_src_tag [QW];
    logic [CW-1:0]          w_sub     [QW];
    logic [NL-1:0][NW-1:0]  n_rem     [QW];
    logic [NL-1:0][QW-1:0]  n_quo     [QW];

    always_comb begin
        w_src_vld[0] = i_valid;
        w_src_rem[0] = i_num;
        w_src_quo[0] = '0;
        w_src_den[0] = i_den;
        w_src_tag[0] = i_tag;
        for (int k = 1; k < QW; k++) begin
            w_src_vld[k] = r_vld[k-1];
            w_src_rem[k] = r_rem[k-1];
            w_src_quo[k] = r_quo[k-1];
            w_src_den[k] = r_den[k-1];
            w_src_tag[k] = r_tag[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            w_sub[k] = CW'(w_src_den[k]) << (QW - 1 - k);
            for (int i = 0; i < NL; i++) begin
                if (CW'(w_src_rem[k][i]) >= w_sub[k]) begin
                    n_rem[k][i] = NW'(CW'(w_src_rem[k][i]) - w_sub[k]);
                    n_quo[k][i] = {w_src_quo[k][i][QW-2:0], 1'b1};
                end else begin
                    n_rem[k][i] = w_src_rem[k][i];
                    n_quo[k][i] = {w_src_quo[k][i][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < QW; k++) r_vld[k] <= w_src_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= w_src_den[k];
                r_tag[k] <= w_src_tag[k];
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_tag   = r_tag[QW-1];

endmodule

// File: rtl/refraction_direction_unit_top.sv
// Refraction direction unit top level: normalize, dot, discriminant, square root, combine.
// Throughput: one beat per cycle unless the output stalls; the length root, the three-lane
// divider and the discriminant root are bit-per-stage pipelines and every stage advances together.
// The whole pipeline holds only while a finished result is stalled at the output.
// Reset: synchronous, active low; clears every stage valid bit, payload is not reset.
module refraction_direction_unit_top #(
    parameter int FRAC_BITS = rdu_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  rdu_pkg::t_rdu_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output rdu_pkg::t_rdu_out o_data
);

    localparam int CW     = rdu_pkg::CALC_W;
    localparam int NL     = rdu_pkg::LANES;
    localparam int LRW    = rdu_pkg::LEN_RAD_W;
    localparam int LW     = rdu_pkg::LEN_W;
    localparam int NW     = FRAC_BITS + 25;
    localparam int QW     = FRAC_BITS + 2;
    localparam int UW     = FRAC_BITS + 3;
    localparam int PUW    = FRAC_BITS + 19;
    localparam int SUMW   = FRAC_BITS + 21;
    localparam int DTW    = 22;
    localparam int DSQW   = 2 * DTW;
    localparam int NDTW   = 16 + DTW;
    localparam int OMW    = (36 - FRAC_BITS > FRAC_BITS + 2) ? 36 - FRAC_BITS : FRAC_BITS + 2;
    localparam int R2W    = 33 - FRAC_BITS;
    localparam int PRW    = R2W + 1 + OMW;
    localparam int TW     = ((FRAC_BITS + 3 > 34 - FRAC_BITS) ? FRAC_BITS + 3
                                                              : 34 - FRAC_BITS) + 1;
    localparam int SQ2_A  = 67 - 2 * FRAC_BITS;
    localparam int SQ2_B  = 2 * FRAC_BITS + 2;
    localparam int SQ2_M  = (SQ2_A > SQ2_B) ? SQ2_A : SQ2_B;
    localparam int SQ2_W  = SQ2_M + (SQ2_M % 2);
    localparam int SRW    = SQ2_W / 2;
    localparam int FW     = ((17 + TW > 17 + SRW) ? 17 + TW : 17 + SRW) + 1;
    localparam int S1_TW  = 16 * NL * 2 + 16 + 1;
    localparam int DV_TW  = 16 * NL + 16 + 1 + NL;
    localparam int S2_TW  = 16 * NL + 16 + TW * NL + 1;
    localparam logic signed [CW-1:0] ONE_F = CW'(1) << FRAC_BITS;

    logic w_en;
    assign w_en    = !o_valid || !i_stall;
    assign o_stall = !w_en;

    // stage A: register the beat, square the direction
    logic                    r_a_vld;
    logic [NL-1:0][15:0]     r_a_d;
    logic [NL-1:0][15:0]     r_a_n;
    logic [15:0]             r_a_r;
    logic [NL-1:0][31:0]     r_a_sq;
    logic [NL-1:0][15:0]     w_in_d;

    assign w_in_d = {i_data.dir_x, i_data.dir_y, i_data.dir_z};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_d <= w_in_d;
            r_a_n <= {i_data.norm_x, i_data.norm_y, i_data.norm_z};
            r_a_r <= i_data.index_ratio;
            for (int i = 0; i < NL; i++) begin
                r_a_sq[i] <= 32'($signed(w_in_d[i]) * $signed(w_in_d[i]));
            end
        end
    end

    // stage B: squared length
    logic                    r_b_vld;
    logic [NL-1:0][15:0]     r_b_d;
    logic [NL-1:0][15:0]     r_b_n;
    logic [15:0]             r_b_r;
    logic [31:0]             r_b_len2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_d    <= r_a_d;
            r_b_n    <= r_a_n;
            r_b_r    <= r_a_r;
            r_b_len2 <= r_a_sq[0] + r_a_sq[1] + r_a_sq[2];
        end
    end

    // length root
    logic                    w_s1_vld;
    logic [LW-1:0]           w_s1_root;
    logic [S1_TW-1:0]        w_s1_tag;
    logic [NL-1:0][15:0]     w_s1_d;
    logic [NL-1:0][15:0]     w_s1_n;
    logic [15:0]             w_s1_r;
    logic                    w_s1_zero;

    rdu_isqrt #(
        .W  (LRW),
        .TW (S1_TW)
    ) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_b_vld),
        .i_rad   ({r_b_len2, 16'd0}),
        .i_tag   ({r_b_d, r_b_n, r_b_r, (r_b_len2 == 32'd0)}),
        .o_valid (w_s1_vld),
        .o_root  (w_s1_root),
        .o_tag   (w_s1_tag)
    );

    assign {w_s1_d, w_s1_n, w_s1_r, w_s1_zero} = w_s1_tag;

    // stage C: divider operands
    logic                    r_c_vld;
    logic [NL-1:0][NW-1:0]   r_c_num;
    logic [LW-1:0]           r_c_den;
    logic [NL-1:0][15:0]     r_c_n;
    logic [15:0]             r_c_r;
    logic                    r_c_zero;
    logic [NL-1:0]           r_c_sgn;
    logic [NL-1:0][15:0]     w_c_mag;

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            w_c_mag[i] = w_s1_d[i][15] ? 16'(-w_s1_d[i]) : w_s1_d[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NL; i++) begin
                r_c_num[i] <= (NW'(w_c_mag[i]) << (FRAC_BITS + 8)) + NW'(w_s1_root >> 1);
                r_c_sgn[i] <= w_s1_d[i][15];
            end
            r_c_den  <= w_s1_zero ? LW'(1) : w_s1_root;
            r_c_n    <= w_s1_n;
            r_c_r    <= w_s1_r;
            r_c_zero <= w_s1_zero;
        end
    end

    // unit vector quotients
    logic                    w_dv_vld;
    logic [NL-1:0][QW-1:0]   w_dv_quo;
    logic [DV_TW-1:0]        w_dv_tag;
    logic [NL-1:0][15:0]     w_dv_n;
    logic [15:0]             w_dv_r;
    logic                    w_dv_zero;
    logic [NL-1:0]           w_dv_sgn;

    rdu_div #(
        .NW (NW),
        .DW (LW),
        .QW (QW),
        .TW (DV_TW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_vld),
        .i_num   (r_c_num),
        .i_den   (r_c_den),
        .i_tag   ({r_c_n, r_c_r, r_c_zero, r_c_sgn}),
        .o_valid (w_dv_vld),
        .o_quo   (w_dv_quo),
        .o_tag   (w_dv_tag)
    );

    assign {w_dv_n, w_dv_r, w_dv_zero, w_dv_sgn} = w_dv_tag;

    // stage D: signed unit vector
    logic                    r_d_vld;
    logic signed [UW-1:0]    r_d_u [NL];
    logic [NL-1:0][15:0]     r_d_n;
    logic [15:0]             r_d_r;
    logic                    r_d_zero;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NL; i++) begin
                r_d_u[i] <= w_dv_sgn[i] ? -$signed(UW'(w_dv_quo[i])) : $signed(UW'(w_dv_quo[i]));
            end
            r_d_n    <= w_dv_n;
            r_d_r    <= w_dv_r;
            r_d_zero <= w_dv_zero;
        end
    end

    // stage E: dot product terms
    logic                    r_e_vld;
    logic signed [PUW-1:0]   r_e_p [NL];
    logic signed [UW-1:0]    r_e_u [NL];
    logic [NL-1:0][15:0]     r_e_n;
    logic [15:0]             r_e_r;
    logic                    r_e_zero;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NL; i++) begin
                r_e_p[i] <= r_d_u[i] * $signed(r_d_n[i]);
                r_e_u[i] <= r_d_u[i];
            end
            r_e_n    <= r_d_n;
            r_e_r    <= r_d_r;
            r_e_zero <= r_d_zero;
        end
    end

    // stage F: dot product
    logic                    r_f_vld;
    logic signed [DTW-1:0]   r_f_dt;
    logic signed [UW-1:0]    r_f_u [NL];
    logic [NL-1:0][15:0]     r_f_n;
    logic [15:0]             r_f_r;
    logic                    r_f_zero;
    logic signed [SUMW-1:0]  w_f_sum;

    assign w_f_sum = SUMW'(r_e_p[0]) + SUMW'(r_e_p[1]) + SUMW'(r_e_p[2]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_dt   <= DTW'(rdu_pkg::rnd_sh(CW'(w_f_sum), FRAC_BITS));
            r_f_u    <= r_e_u;
            r_f_n    <= r_e_n;
            r_f_r    <= r_e_r;
            r_f_zero <= r_e_zero;
        end
    end

    // stage G: squares and normal scaled by the dot product
    logic                    r_g_vld;
    logic signed [DSQW-1:0]  r_g_dsq;
    logic [31:0]             r_g_rr;
    logic signed [NDTW-1:0]  r_g_ndt [NL];
    logic signed [UW-1:0]    r_g_u [NL];
    logic [NL-1:0][15:0]     r_g_n;
    logic [15:0]             r_g_r;
    logic                    r_g_zero;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_dsq <= r_f_dt * r_f_dt;
            r_g_rr  <= r_f_r * r_f_r;
            for (int i = 0; i < NL; i++) begin
                r_g_ndt[i] <= $signed(r_f_n[i]) * r_f_dt;
            end
            r_g_u    <= r_f_u;
            r_g_n    <= r_f_n;
            r_g_r    <= r_f_r;
            r_g_zero <= r_f_zero;
        end
    end

    // stage H: one minus dot squared, ratio squared, tangent part
    logic                    r_h_vld;
    logic signed [OMW-1:0]   r_h_om;
    logic [R2W-1:0]          r_h_r2;
    logic [NL-1:0][TW-1:0]   r_h_t;
    logic [NL-1:0][15:0]     r_h_n;
    logic [15:0]             r_h_r;
    logic                    r_h_zero;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_om <= OMW'(ONE_F - rdu_pkg::rnd_sh(CW'(r_g_dsq), FRAC_BITS));
            r_h_r2 <= R2W'(rdu_pkg::rnd_sh(CW'(r_g_rr), FRAC_BITS));
            for (int i = 0; i < NL; i++) begin
                r_h_t[i] <= TW'(CW'(r_g_u[i]) - rdu_pkg::rnd_sh(CW'(r_g_ndt[i]), FRAC_BITS));
            end
            r_h_n    <= r_g_n;
            r_h_r    <= r_g_r;
            r_h_zero <= r_g_zero;
        end
    end

    // stage I: ratio squared times one minus dot squared
    logic                    r_i_vld;
    logic signed [PRW-1:0]   r_i_pr;
    logic [NL-1:0][TW-1:0]   r_i_t;
    logic [NL-1:0][15:0]     r_i_n;
    logic [15:0]             r_i_r;
    logic                    r_i_zero;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_i_pr   <= $signed({1'b0, r_h_r2}) * r_h_om;
            r_i_t    <= r_h_t;
            r_i_n    <= r_h_n;
            r_i_r    <= r_h_r;
            r_i_zero <= r_h_zero;
        end
    end

    // stage J: discriminant and refraction decision
    logic                    r_j_vld;
    logic [SQ2_W-1:0]        r_j_rad;
    logic                    r_j_ok;
    logic [NL-1:0][TW-1:0]   r_j_t;
    logic [NL-1:0][15:0]     r_j_n;
    logic [15:0]             r_j_r;
    logic signed [CW-1:0]    w_j_disc;
    logic                    w_j_ok;

    assign w_j_disc = ONE_F - rdu_pkg::rnd_sh(CW'(r_i_pr), FRAC_BITS);
    assign w_j_ok   = !r_i_zero && (w_j_disc > 0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_j_rad <= w_j_ok ? SQ2_W'(w_j_disc <<< FRAC_BITS) : '0;
            r_j_ok  <= w_j_ok;
            r_j_t   <= r_i_t;
            r_j_n   <= r_i_n;
            r_j_r   <= r_i_r;
        end
    end

    // discriminant root
    logic                    w_s2_vld;
    logic [SRW-1:0]          w_s2_root;
    logic [S2_TW-1:0]        w_s2_tag;
    logic [NL-1:0][15:0]     w_s2_n;
    logic [15:0]             w_s2_r;
    logic [NL-1:0][TW-1:0]   w_s2_t;
    logic                    w_s2_ok;

    rdu_isqrt #(
        .W  (SQ2_W),
        .TW (S2_TW)
    ) u_disc_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_j_vld),
        .i_rad   (r_j_rad),
        .i_tag   ({r_j_n, r_j_r, r_j_t, r_j_ok}),
        .o_valid (w_s2_vld),
        .o_root  (w_s2_root),
        .o_tag   (w_s2_tag)
    );

    assign {w_s2_n, w_s2_r, w_s2_t, w_s2_ok} = w_s2_tag;

    // stage K: combine terms
    logic                    r_k_vld;
    logic signed [FW-1:0]    r_k_rt [NL];
    logic signed [FW-1:0]    r_k_ns [NL];
    logic                    r_k_ok;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NL; i++) begin
                r_k_rt[i] <= $signed({1'b0, w_s2_r}) * $signed(w_s2_t[i]);
                r_k_ns[i] <= $signed(w_s2_n[i]) * $signed({1'b0, w_s2_root});
            end
            r_k_ok <= w_s2_ok;
        end
    end

    // stage L: round, saturate, output register
    logic                    r_o_vld;
    rdu_pkg::t_rdu_out       r_o_data;
    logic signed [15:0]      w_l_out [NL];

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            w_l_out[i] = r_k_ok ? rdu_pkg::sat16(rdu_pkg::rnd_sh(CW'(r_k_rt[i]) - CW'(r_k_ns[i]),
                                                                 FRAC_BITS))
                                : 16'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_data.out_x <= w_l_out[2];
            r_o_data.out_y <= w_l_out[1];
            r_o_data.out_z <= w_l_out[0];
            r_o_data.ok    <= r_k_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            r_i_vld <= 1'b0;
            r_j_vld <= 1'b0;
            r_k_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= w_s1_vld;
            r_d_vld <= w_dv_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
            r_i_vld <= r_h_vld;
            r_j_vld <= r_i_vld;
            r_k_vld <= w_s2_vld;
            r_o_vld <= r_k_vld;
        end
    end

    assign o_valid = r_o_vld;
    assign o_data  = r_o_data;

endmodule

// File: rtl/rdu_chk.sv
// Port-level checks for the refraction direction unit, bound to the top level.
module rdu_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input rdu_pkg::t_rdu_in  i_data,
    input logic              o_valid,
    input logic              i_stall,
    input rdu_pkg::t_rdu_out o_data
);

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output is free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled output beat changed");

    a_no_refract_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.ok) |->
            (o_data.out_x == 16'sd0 && o_data.out_y == 16'sd0 && o_data.out_z == 16'sd0))
        else $error("nonzero vector without refraction");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind refraction_direction_unit_top rdu_chk u_rdu_chk (.*);
